>>> design/ssr_pkg.sv
package ssr_pkg;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned TOT_W = 16;

  localparam logic [1:0] CFG_PATTERN_BYTES = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LEN   = 2'd1;
  localparam logic [1:0] CFG_REPL_BYTES    = 2'd2;
  localparam logic [1:0] CFG_REPL_LEN      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_REPL,
    S_FLUSH
  } state_e;

  // Result of comparing the pending bytes against the pattern.
  typedef struct packed {
    logic prefix_ok;
    logic whole;
  } cmp_t;

endpackage

>>> design/stream_substring_replace.sv
// Streaming search and replace of a byte pattern.
// Input channel: one beat carries a text byte, or an end-of-text mark that
// flushes held bytes and closes the string. Output channel: one beat per
// released text byte or replacement byte, and after end of text a final
// beat with char_valid low, final_marker high and the saturating
// replacement count.
// A byte is taken while the sequencer is idle and checked against the
// pattern in the cycle after. Every emitted beat (a released byte or a
// replacement byte) passes through the single compare/emit sequencer and
// the one-deep output register. in_stall_o is low only while the
// sequencer is idle. When the receiver stalls, the output beat holds and
// the sequencer waits before emitting its next beat.
// Reset empties the held bytes by clearing the fill count, clears the
// replacement count and loads the register reset values (pattern length 1,
// others zero). Configuration is written only while the block is idle:
// the user must keep to this, as the block itself does not enforce it.
module stream_substring_replace
  import ssr_pkg::*;
#(
  parameter int unsigned PATTERN_MAX     = 8,
  parameter int unsigned REPLACEMENT_MAX = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_char_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             char_valid_o,
  output logic             final_marker_o,
  output logic [TOT_W-1:0] replace_total_o
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] pattern_q, repl_q;
  logic [CNT_W-1:0] plen_raw_q, rlen_raw_q;
  logic [CNT_W-1:0] plen, rlen;

  logic [DEPTH-1:0][7:0] pend_q;
  logic [CNT_W-1:0]      count_q;
  logic [TOT_W-1:0]      total_q;
  logic [IDX_W-1:0]      ridx_q;

  logic             out_valid_q;
  logic [7:0]       out_char_q;
  logic             char_valid_q;
  logic             final_q;
  logic [TOT_W-1:0] out_total_q;

  cmp_t cmp;
  logic in_acc, out_free;
  logic emit, emit_cv, emit_fin;
  logic [7:0] emit_char;
  logic [TOT_W-1:0] emit_total;
  logic do_release, do_match, do_repl, do_final;

  assign plen = (plen_raw_q == '0) ? CNT_W'(1) :
                (plen_raw_q > CNT_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX) : plen_raw_q;
  assign rlen = (rlen_raw_q > CNT_W'(REPLACEMENT_MAX)) ? CNT_W'(REPLACEMENT_MAX) : rlen_raw_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  ssr_prefix_cmp u_cmp (
    .pend_i    (pend_q),
    .count_i   (count_q),
    .pattern_i (pattern_q),
    .plen_i    (plen),
    .cmp_o     (cmp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = end_of_text_i ? S_FLUSH : S_CHECK;
        end
      end
      S_CHECK: begin
        if (count_q == '0) begin
          state_d = S_IDLE;
        end else if (cmp.prefix_ok) begin
          state_d = (cmp.whole && rlen != '0) ? S_REPL : S_IDLE;
        end
      end
      S_REPL: begin
        if (out_free && ({1'b0, ridx_q} + CNT_W'(1)) == rlen) begin
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free && count_q == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    emit_char  = pend_q[0];
    emit_cv    = 1'b1;
    emit_fin   = 1'b0;
    emit_total = '0;
    do_release = 1'b0;
    do_match   = 1'b0;
    do_repl    = 1'b0;
    do_final   = 1'b0;
    unique case (state_q)
      S_IDLE: ;
      S_CHECK: begin
        if (count_q != '0) begin
          if (cmp.prefix_ok) begin
            do_match = cmp.whole;
          end else if (out_free) begin
            emit       = 1'b1;
            do_release = 1'b1;
          end
        end
      end
      S_REPL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = repl_q[{ridx_q, 3'b000} +: 8];
          do_repl   = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (count_q != '0) begin
            do_release = 1'b1;
          end else begin
            emit_char  = '0;
            emit_cv    = 1'b0;
            emit_fin   = 1'b1;
            emit_total = total_q;
            do_final   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pattern_q  <= '0;
      plen_raw_q <= CNT_W'(1);
      repl_q     <= '0;
      rlen_raw_q <= '0;
      count_q    <= '0;
      total_q    <= '0;
      ridx_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PATTERN_BYTES: pattern_q  <= cfg_data_i;
          CFG_PATTERN_LEN:   plen_raw_q <= cfg_data_i[CNT_W-1:0];
          CFG_REPL_BYTES:    repl_q     <= cfg_data_i;
          CFG_REPL_LEN:      rlen_raw_q <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && !end_of_text_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_release) begin
        count_q <= count_q - CNT_W'(1);
      end else if (do_match) begin
        count_q <= '0;
      end
      if (do_match) begin
        ridx_q <= '0;
        if (total_q != '1) begin
          total_q <= total_q + TOT_W'(1);
        end
      end else if (do_repl) begin
        ridx_q <= ridx_q + IDX_W'(1);
      end else if (do_final) begin
        total_q <= '0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending bytes and the output beat carry no reset; the fill count and
  // the valid flag guard them.
  always_ff @(posedge clk_i) begin
    if (in_acc && !end_of_text_i) begin
      pend_q[count_q[IDX_W-1:0]] <= in_char_i;
    end else if (do_release) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        pend_q[i] <= pend_q[i+1];
      end
      pend_q[DEPTH-1] <= '0;
    end
    if (emit) begin
      out_char_q   <= emit_char;
      char_valid_q <= emit_cv;
      final_q      <= emit_fin;
      out_total_q  <= emit_total;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign char_valid_o    = char_valid_q;
  assign final_marker_o  = final_q;
  assign replace_total_o = out_total_q;

endmodule

>>> design/ssr_prefix_cmp.sv
module ssr_prefix_cmp
  import ssr_pkg::*;
(
  input  logic [DEPTH-1:0][7:0] pend_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [CFG_W-1:0]      pattern_i,
  input  logic [CNT_W-1:0]      plen_i,
  output cmp_t                  cmp_o
);

  logic [DEPTH-1:0] byte_ok;

  // Each pending slot is checked against its pattern byte; slots past the
  // fill level do not take part.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      byte_ok[i] = (CNT_W'(i) >= count_i) || (pend_i[i] == pattern_i[8*i +: 8]);
    end
  end

  assign cmp_o.prefix_ok = (count_i <= plen_i) && (&byte_ok);
  assign cmp_o.whole     = (count_i == plen_i);

endmodule

>>> design/ssr_checker.sv
module ssr_checker
  import ssr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [7:0]       out_char_o,
  input logic             char_valid_o,
  input logic             final_marker_o,
  input logic [TOT_W-1:0] replace_total_o
);

  // A stalled output beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) &&
      $stable(char_valid_o) && $stable(final_marker_o) && $stable(replace_total_o))
    else $error("output beat changed while stalled");

  // Every accepted input beat moves the sequencer out of idle, so the input side closes in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again without a check cycle");

  a_final_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_marker_o |-> !char_valid_o && out_char_o == 8'd0)
    else $error("final beat carries a text byte");

  a_text_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> !final_marker_o && replace_total_o == '0)
    else $error("text beat carries a count or a final flag");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int unsigned PAT_MAX = 8;
  localparam int unsigned REP_MAX = 8;

  typedef struct packed {
    logic [7:0]       ch;
    logic             is_char;
    logic             fin;
    logic [TOT_W-1:0] total;
  } text_beat_t;

  // Tracks the substitution state seen by the DUT and holds the beats it owes.
  class replace_scoreboard;
    logic [63:0]      pat_bytes = '0;
    logic [3:0]       pat_len = 4'd1;
    logic [63:0]      rep_bytes = '0;
    logic [3:0]       rep_len = '0;
    logic [7:0]       held [DEPTH];
    int unsigned      held_n = 0;
    logic [TOT_W-1:0] match_cnt = '0;
    text_beat_t       awaited [$];
    int unsigned      errors = 0;

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_PATTERN_BYTES: pat_bytes = data;
        CFG_PATTERN_LEN:   pat_len = data[3:0];
        CFG_REPL_BYTES:    rep_bytes = data;
        CFG_REPL_LEN:      rep_len = data[3:0];
        default: ;
      endcase
    endfunction

    function void release_oldest();
      awaited.push_back(text_beat_t'{held[0], 1'b1, 1'b0, '0});
      for (int i = 0; i < DEPTH - 1; i++) held[i] = held[i+1];
      held[DEPTH-1] = '0;
      held_n--;
    endfunction

    function bit prefix_ok(int unsigned plen);
      if (held_n > plen) return 0;
      for (int i = 0; i < held_n; i++)
        if (held[i] != pat_bytes[8*i +: 8]) return 0;
      return 1;
    endfunction

    function void clear_held();
      foreach (held[i]) held[i] = '0;
      held_n = 0;
    endfunction

    function void take_input(logic [7:0] ch, logic eot);
      int unsigned plen;
      int unsigned rlen;
      plen = (pat_len == 0) ? 1 : ((pat_len > PAT_MAX) ? PAT_MAX : pat_len);
      if (eot) begin
        while (held_n > 0) release_oldest();
        awaited.push_back(text_beat_t'{8'h00, 1'b0, 1'b1, match_cnt});
        clear_held();
        match_cnt = '0;
        return;
      end
      // A pattern shortened mid-string may have left the buffer full.
      while (held_n >= DEPTH) release_oldest();
      held[held_n] = ch;
      held_n++;
      while (held_n > 0) begin
        if (prefix_ok(plen)) begin
          if (held_n == plen) begin
            rlen = (rep_len > REP_MAX) ? REP_MAX : rep_len;
            for (int r = 0; r < rlen; r++)
              awaited.push_back(text_beat_t'{rep_bytes[8*r +: 8], 1'b1, 1'b0, '0});
            clear_held();
            if (match_cnt != '1) match_cnt++;
          end
          break;
        end
        release_oldest();
      end
    endfunction

    function void check_beat(text_beat_t got);
      text_beat_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected beat, got char %h valid %b final %b total %0d", $time,
                 got.ch, got.is_char, got.fin, got.total);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.ch !== want.ch) begin
        $display("%0t: out_char expected %h got %h", $time, want.ch, got.ch);
        errors++;
      end
      if (got.is_char !== want.is_char) begin
        $display("%0t: char_valid expected %b got %b", $time, want.is_char, got.is_char);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: final_marker expected %b got %b", $time, want.fin, got.fin);
        errors++;
      end
      if (got.total !== want.total) begin
        $display("%0t: replace_total expected %0d got %0d", $time, want.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       in_char_i;
  logic             end_of_text_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       out_char_o;
  logic             char_valid_o;
  logic             final_marker_o;
  logic [TOT_W-1:0] replace_total_o;

  replace_scoreboard sb;

  bit          tx_idle;
  bit          rx_idle;
  bit          rx_hold_req;
  int unsigned text_sent;
  logic [63:0] cur_pat;
  int unsigned cur_plen;

  stream_substring_replace u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_char_i      (in_char_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .char_valid_o   (char_valid_o),
    .final_marker_o (final_marker_o),
    .replace_total_o(replace_total_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.take_input(in_char_i, end_of_text_i);
      if (out_valid_o && !out_stall_i)
        sb.check_beat(text_beat_t'{out_char_o, char_valid_o, final_marker_o,
                                   replace_total_o});
    end
  end

  // Receiver: a random hold-off before each beat while rx_idle is set, and one long hold on request.
  initial begin
    int unsigned w;
    out_stall_i = 1'b0;
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      w = rx_idle ? $urandom_range(0, 19) : 0;
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Leaves in_valid_i high after the beat is taken; the next call or
  // drain_and_pause decides what it does next.
  task automatic send_item(input logic [7:0] ch, input logic eot);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_char_i     <= ch;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    text_sent++;
  endtask

  // Held bytes never produce a beat on their own, so a fixed pause follows
  // the drain to let the sequencer return to idle. The first edge lets the
  // monitor record the last input beat before the queue is looked at.
  task automatic drain_and_pause();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_PATTERN_BYTES) cur_pat = data;
    if (idx == CFG_PATTERN_LEN)
      cur_plen = (data[3:0] == 0) ? 1 : ((data[3:0] > PAT_MAX) ? PAT_MAX : data[3:0]);
  endtask

  function automatic logic [7:0] alpha_byte();
    return $urandom_range(0, 1) ? 8'h61 : 8'h62;
  endfunction

  task automatic send_text(input logic [63:0] bytes, input int unsigned n);
    for (int i = 0; i < n; i++) send_item(bytes[8*i +: 8], 1'b0);
  endtask

  initial begin
    int unsigned phase;
    int unsigned start;
    int unsigned len;
    int unsigned tok;
    int unsigned cut;
    int unsigned mode;
    logic [63:0] v;

    sb            = new;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PATTERN_BYTES;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_char_i     = '0;
    end_of_text_i = 1'b0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    rx_hold_req   = 1'b0;
    text_sent     = 0;
    cur_pat       = '0;
    cur_plen      = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: a one-byte pattern of zero that is deleted.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b0);
    send_item(8'hFF, 1'b1);
    drain_and_pause();

    // Overlapping start: "aab" under pattern "ab" needs a rescan.
    write_reg(CFG_PATTERN_BYTES, 64'h6261);
    write_reg(CFG_PATTERN_LEN, 64'd2);
    write_reg(CFG_REPL_BYTES, 64'h5A5958);
    write_reg(CFG_REPL_LEN, 64'd3);
    send_text(64'h6361626161, 5);
    send_item(8'h00, 1'b1);
    drain_and_pause();

    // Zero pattern length acts as one; oversized replacement length clamps.
    write_reg(CFG_PATTERN_BYTES, '1);
    write_reg(CFG_PATTERN_LEN, 64'd0);
    write_reg(CFG_REPL_BYTES, '1);
    write_reg(CFG_REPL_LEN, 64'd15);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    drain_and_pause();

    // Oversized pattern length clamps to eight bytes; matches are deleted.
    write_reg(CFG_PATTERN_LEN, 64'd15);
    write_reg(CFG_REPL_LEN, 64'd0);
    send_text('1, 8);
    drain_and_pause();

    // Pattern swapped while bytes are held: they no longer form a prefix.
    write_reg(CFG_PATTERN_BYTES, 64'h636261);
    write_reg(CFG_PATTERN_LEN, 64'd3);
    send_text(64'h6261, 2);
    drain_and_pause();
    write_reg(CFG_PATTERN_BYTES, 64'h7978);
    write_reg(CFG_PATTERN_LEN, 64'd2);
    send_text(64'h7978, 2);
    send_item(8'hFF, 1'b1);
    drain_and_pause();

    phase = 0;
    start = text_sent;
    while (text_sent - start < 400) begin
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        mode = $urandom_range(0, 9);
        if (mode < 6)
          for (int i = 0; i < 8; i++) v[8*i +: 8] = alpha_byte();
        else if (mode < 8) v = {$urandom, $urandom};
        else if (mode == 8) v = '1;
        else v = '0;
        write_reg(CFG_PATTERN_BYTES, v);
      end
      if (phase == 0 || $urandom_range(0, 9) < 7) begin
        mode = $urandom_range(0, 9);
        if (mode < 6) v = 64'($urandom_range(1, 4));
        else if (mode < 8) v = 64'($urandom_range(5, 8));
        else v = 64'($urandom_range(0, 15));
        write_reg(CFG_PATTERN_LEN, v);
      end
      if (phase == 0 || $urandom_range(0, 9) < 7)
        write_reg(CFG_REPL_BYTES, {$urandom, $urandom});
      if (phase == 0 || $urandom_range(0, 9) < 7)
        write_reg(CFG_REPL_LEN, 64'($urandom_range(0, 15)));

      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      len = $urandom_range(15, 50);
      if (phase == 1) begin
        // Back-to-back input against a receiver that holds off for a long time.
        tx_idle = 1'b0;
        rx_hold_req = 1'b1;
        len = 60;
      end

      cut = text_sent;
      while (text_sent - cut < len) begin
        tok = $urandom_range(0, 99);
        if (tok < 35) begin
          send_text(cur_pat, cur_plen);
        end else if (tok < 55) begin
          send_text(cur_pat, $urandom_range(0, cur_plen - 1));
          send_item(alpha_byte(), 1'b0);
        end else if (tok < 80) begin
          send_item(alpha_byte(), 1'b0);
        end else if (tok < 95) begin
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b1);
        end
      end
      // Without an end beat the next settings apply to a string in progress.
      if ($urandom_range(0, 9) < 7) send_item(8'($urandom_range(0, 255)), 1'b1);
      drain_and_pause();
      phase++;
    end

    send_item(8'($urandom_range(0, 255)), 1'b1);
    drain_and_pause();

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> stream_substring_replace.f
design/ssr_pkg.sv
design/ssr_prefix_cmp.sv
design/stream_substring_replace.sv
design/ssr_checker.sv
verif/tb.sv
